// ===== rtl/bsf_pkg.sv =====
package bsf_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_MASK  = 8'h20;

    // The longest expansion of one input word is six line words.
    localparam int SEQ_DEPTH = 6;
    localparam int CNT_W     = 3;

    typedef struct packed {
        logic [SEQ_DEPTH-1:0][7:0] bytes;
        logic [SEQ_DEPTH-1:0]      done;
        logic [CNT_W-1:0]          cnt;
    } t_seq;

    typedef struct packed {
        logic free;
        logic busy;
    } t_emit_stat;

    function automatic t_seq f_push(t_seq s, logic [7:0] b, logic dn);
        t_seq r;
        r = s;
        r.bytes[s.cnt] = b;
        r.done[s.cnt]  = dn;
        r.cnt          = s.cnt + CNT_W'(1);
        return r;
    endfunction

    function automatic t_seq f_push_stuffed(t_seq s, logic [7:0] b);
        t_seq r;
        if (b == FLAG_BYTE || b == ESC_BYTE) begin
            r = f_push(s, ESC_BYTE, 1'b0);
            r = f_push(r, b ^ ESC_MASK, 1'b0);
        end else begin
            r = f_push(s, b, 1'b0);
        end
        return r;
    endfunction

endpackage

// ===== rtl/bsf_frame.sv =====
module bsf_frame (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic          i_kind,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    output bsf_pkg::t_seq o_seq
);
    import bsf_pkg::*;

    logic       r_in_frame, n_in_frame;
    logic [7:0] r_xor, n_xor;
    logic [7:0] x_cur;
    t_seq       s;

    // Expand one input word into its list of line words and the next state.
    always_comb begin
        s          = '0;
        n_in_frame = r_in_frame;
        n_xor      = r_xor;
        x_cur      = r_in_frame ? r_xor : 8'h00;
        if (i_kind) begin
            if (r_in_frame) begin
                s = f_push_stuffed(s, r_xor);
                s = f_push(s, FLAG_BYTE, 1'b1);
            end
            s          = f_push(s, FLAG_BYTE, 1'b0);
            s          = f_push(s, 8'h00, 1'b0);
            s          = f_push(s, FLAG_BYTE, 1'b1);
            n_in_frame = 1'b0;
            n_xor      = 8'h00;
        end else begin
            if (!r_in_frame) begin
                s = f_push(s, FLAG_BYTE, 1'b0);
            end
            s     = f_push_stuffed(s, i_data_byte);
            n_xor = x_cur ^ i_data_byte;
            if (i_last_byte) begin
                s          = f_push_stuffed(s, n_xor);
                s          = f_push(s, FLAG_BYTE, 1'b1);
                n_in_frame = 1'b0;
                n_xor      = 8'h00;
            end else begin
                n_in_frame = 1'b1;
            end
        end
    end

    assign o_seq = s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_xor      <= 8'h00;
        end else if (i_take) begin
            r_in_frame <= n_in_frame;
            r_xor      <= n_xor;
        end
    end

endmodule

// ===== rtl/bsf_emit.sv =====
module bsf_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  bsf_pkg::t_seq       i_seq,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [7:0]          o_line_byte,
    output logic                o_frame_done,
    output logic                o_run_last,
    output bsf_pkg::t_emit_stat o_stat
);
    import bsf_pkg::*;

    t_seq             r_seq;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_busy, n_busy;
    logic             r_ovalid, n_ovalid;
    logic [7:0]       r_line;
    logic             r_done;
    logic             r_last;
    logic             out_free;
    logic             on_last;
    logic             move;

    always_comb begin
        out_free = !r_ovalid || !i_out_stall;
        on_last  = (r_idx == (r_seq.cnt - CNT_W'(1)));
        move     = r_busy && out_free;

        n_busy = r_busy;
        if (move && on_last) begin
            n_busy = 1'b0;
        end
        if (i_load) begin
            n_busy = 1'b1;
        end

        n_idx = r_idx;
        if (i_load) begin
            n_idx = '0;
        end else if (move) begin
            n_idx = r_idx + CNT_W'(1);
        end

        n_ovalid = r_ovalid;
        if (out_free) begin
            n_ovalid = r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_seq <= i_seq;
        end
        if (move) begin
            r_line <= r_seq.bytes[r_idx];
            r_done <= r_seq.done[r_idx];
            r_last <= on_last;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_line_byte  = r_line;
    assign o_frame_done = r_done;
    assign o_run_last   = r_last;
    assign o_stat.free  = !r_busy || (move && on_last);
    assign o_stat.busy  = r_busy;

endmodule

// ===== rtl/byte_stuffing_framer_xor_check_top.sv =====
// Byte-stuffing framer with an XOR check byte. Each accepted input word
// (a payload byte, or an empty-frame request) is expanded into a list of
// one to six line words that is held in a sequence buffer, and the list is
// then moved one line word per cycle, while the output is not stalled, into
// the output register. The output register is one byte wide, so the line
// words of a list leave the output one after another. The next input word
// is accepted in the same cycle that the last line word of the current list
// moves to the output, so the block can take a new word before the last line
// word of the previous one has left the output. The line words of an input
// word pass through the sequence buffer and then the output register before
// they appear on the output. The opening flag is sent before the first byte
// of a frame, bytes 0x7E and 0x7D are sent as 0x7D and the byte XOR 0x20,
// and the byte marked last is followed by the stuffed XOR of the frame's raw
// bytes and a closing flag that carries frame_done. An empty-frame request
// first closes any open frame and then sends flag, 00, flag. The run_last
// bit marks the final line word caused by each input.
module byte_stuffing_framer_xor_check_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_line_byte,
    output logic       o_frame_done,
    output logic       o_run_last
);
    import bsf_pkg::*;

    t_seq       seq;
    t_emit_stat stat;
    logic       accept;

    // A word is taken whenever the sequence buffer is empty or is handing
    // its last line word to the output register in this cycle.
    assign accept     = i_in_valid && stat.free;
    assign o_in_stall = !stat.free;

    // Frame state and the expansion of one input word into line words.
    bsf_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (accept),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_seq       (seq)
    );

    // Sequence buffer and output register.
    bsf_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_seq        (seq),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_line_byte  (o_line_byte),
        .o_frame_done (o_frame_done),
        .o_run_last   (o_run_last),
        .o_stat       (stat)
    );

    // An accepted word always leaves a list in the sequence buffer.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> stat.busy)
        else $error("sequence buffer empty after an accepted word");

    // A closing flag is always the flag byte.
    a_done_is_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> (o_line_byte == FLAG_BYTE))
        else $error("frame_done on a byte other than the flag");

    // An escape byte is never the last word of a run and is followed at
    // once by an escaped flag or escape byte.
    a_esc_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_line_byte == ESC_BYTE) |=>
        (o_out_valid && (o_line_byte == (FLAG_BYTE ^ ESC_MASK) ||
                         o_line_byte == (ESC_BYTE ^ ESC_MASK))))
        else $error("escape byte not followed by an escaped byte");

    a_esc_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_run_last) |-> (o_line_byte != ESC_BYTE))
        else $error("run ends on an escape byte");

endmodule

// ===== dv/tb_byte_stuffing_framer_xor_check_top.sv =====
module tb_byte_stuffing_framer_xor_check_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bsf_pkg::FLAG_BYTE;
    import bsf_pkg::ESC_BYTE;
    import bsf_pkg::ESC_MASK;

    // The input word either carries one payload byte or asks for an empty frame.
    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_EMPTY   = 1'b1
    } t_kind;

    // An empty frame carries the XOR of zero bytes as its check byte.
    localparam logic [7:0] EMPTY_CHECK = 8'h00;

    // One line word as it should leave the block.
    typedef struct packed {
        logic [7:0] line;
        logic       done;
        logic       last;
    } t_line_word;

    // A row of the directed table. When n_fixed is nonzero, the line words
    // are typed into the row. Otherwise they come from the frame expander.
    typedef struct packed {
        t_kind           kind;
        logic [7:0]      data;
        logic            last;
        int              n_fixed;
        logic [0:5][7:0] fixed_line;
        logic [0:5]      fixed_done;
    } t_dir_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       kind = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] line_byte;
    logic       frame_done;
    logic       run_last;

    // Line words still owed by the block, oldest first.
    t_line_word line_q[$];
    // Line words that the most recent input word expands into.
    t_line_word expand_q[$];
    t_dir_row   dir_tab[$];

    // Framer state as the testbench tracks it.
    logic       frm_open = 1'b0;
    logic [7:0] frm_xor = 8'h00;

    int  err_cnt = 0;
    int  words_sent = 0;
    // While idle_on is set, both sides insert random idle bursts.
    bit  idle_on = 1'b1;
    // A request to the receiver for one long hold-off.
    bit  hold_req = 1'b0;

    byte_stuffing_framer_xor_check_top u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_kind       (kind),
        .i_data_byte  (data_byte),
        .i_last_byte  (last_byte),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_line_byte  (line_byte),
        .o_frame_done (frame_done),
        .o_run_last   (run_last)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The run must finish well within this time even with the heaviest
    // idling. If it does not, the block has hung or lost words.
    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Frame expander. It keeps its own copy of the open-frame flag and the
    // running XOR, and turns one input word into the line words it causes.
    // ------------------------------------------------------------------
    function automatic void put_line(input logic [7:0] b, input logic dn);
        t_line_word w;
        w.line = b;
        w.done = dn;
        w.last = 1'b0;
        expand_q.push_back(w);
    endfunction

    // Flag and escape bytes go out as the escape byte and the byte with
    // bit 5 flipped. Every other byte goes out as it is.
    function automatic void put_escaped(input logic [7:0] b);
        if (b == FLAG_BYTE || b == ESC_BYTE) begin
            put_line(ESC_BYTE, 1'b0);
            put_line(b ^ ESC_MASK, 1'b0);
        end else begin
            put_line(b, 1'b0);
        end
    endfunction

    // The check byte is escaped like payload, and the closing flag is the
    // only line word that carries frame_done.
    function automatic void shut_frame();
        put_escaped(frm_xor);
        put_line(FLAG_BYTE, 1'b1);
        frm_open = 1'b0;
        frm_xor  = 8'h00;
    endfunction

    function automatic void expand_word(input t_kind k, input logic [7:0] d, input logic l);
        t_line_word w;
        expand_q.delete();
        if (k == KIND_EMPTY) begin
            // An open frame is closed before the empty frame goes out.
            if (frm_open) begin
                shut_frame();
            end
            put_line(FLAG_BYTE, 1'b0);
            put_line(EMPTY_CHECK, 1'b0);
            put_line(FLAG_BYTE, 1'b1);
        end else begin
            if (!frm_open) begin
                put_line(FLAG_BYTE, 1'b0);
                frm_open = 1'b1;
                frm_xor  = 8'h00;
            end
            put_escaped(d);
            frm_xor = frm_xor ^ d;
            if (l) begin
                shut_frame();
            end
        end
        // The last line word of each input word carries run_last.
        w = expand_q[expand_q.size() - 1];
        w.last = 1'b1;
        expand_q[expand_q.size() - 1] = w;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Valid stays high from one word to the next unless an idle
    // burst is inserted, so it is never lowered and raised in one step.
    // The task returns at the clock edge at which the word is taken.
    // ------------------------------------------------------------------
    task automatic offer_word(input t_kind k, input logic [7:0] d, input logic l);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        data_byte <= d;
        last_byte <= l;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    // Offers one word and files the line words the expander predicts.
    task automatic send_checked(input t_kind k, input logic [7:0] d, input logic l);
        int i;
        offer_word(k, d, l);
        expand_word(k, d, l);
        for (i = 0; i < expand_q.size(); i++) begin
            line_q.push_back(expand_q[i]);
        end
    endtask

    // The sender drops valid and waits until every owed line word is out.
    task automatic drain_lines();
        in_valid <= 1'b0;
        @(posedge clk);
        while (line_q.size() != 0) begin
            @(posedge clk);
        end
    endtask

    function automatic void add_row(input t_kind k, input logic [7:0] d, input logic l,
                                    input int n, input logic [0:5][7:0] ln,
                                    input logic [0:5] dn);
        t_dir_row r;
        r.kind       = k;
        r.data       = d;
        r.last       = l;
        r.n_fixed    = n;
        r.fixed_line = ln;
        r.fixed_done = dn;
        dir_tab.push_back(r);
    endfunction

    // Payload bytes favor the two bytes that need escaping.
    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 7))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed frames with random content. Now and then a long
    // frame, a frame cut short by an empty-frame word, or a stray empty-frame
    // word whose ignored fields hold random values.
    task automatic send_random_frame();
        int          len;
        int          i;
        int          pick;
        logic [7:0]  b;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            send_checked(KIND_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
            len = (pick == 1) ? $urandom_range(12, 40) : $urandom_range(1, 8);
            for (i = 0; i < len; i++) begin
                b = pick_payload();
                send_checked(KIND_PAYLOAD, b, (pick != 2) && (i == len - 1));
            end
            if (pick == 2) begin
                send_checked(KIND_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver. It stalls in random bursts while idling is on, and holds
    // off for one long stretch when asked, so that the block fills up.
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (idle_on && rst_n && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Every line word taken from the block is checked field by field
    // against the oldest one still owed.
    always @(posedge clk) begin : line_check
        t_line_word w;
        if (rst_n && out_valid && !out_stall) begin
            if (line_q.size() == 0) begin
                flag_mismatch($sformatf("line word %02h with none owed", line_byte));
            end else begin
                w = line_q.pop_front();
                if (line_byte !== w.line) begin
                    flag_mismatch($sformatf("line_byte %02h, owed %02h", line_byte, w.line));
                end
                if (frame_done !== w.done) begin
                    flag_mismatch($sformatf("frame_done %0b, owed %0b on %02h",
                                            frame_done, w.done, w.line));
                end
                if (run_last !== w.last) begin
                    flag_mismatch($sformatf("run_last %0b, owed %0b on %02h",
                                            run_last, w.last, w.line));
                end
            end
        end
    end

    initial begin : stimulus
        int         i;
        t_dir_row   row;
        t_line_word w;

        // Directed words. The first ones come straight after reset and
        // their line words are typed in; the rest rely on the expander.
        // An empty frame right after reset, then again with junk in the
        // fields it ignores.
        add_row(KIND_EMPTY, 8'h00, 1'b0, 3, {FLAG_BYTE, EMPTY_CHECK, FLAG_BYTE, 24'h0},
                6'b001000);
        add_row(KIND_EMPTY, 8'hFF, 1'b1, 3, {FLAG_BYTE, EMPTY_CHECK, FLAG_BYTE, 24'h0},
                6'b001000);
        // Single-byte frames at the extremes of the byte.
        add_row(KIND_PAYLOAD, 8'h00, 1'b1, 4, {FLAG_BYTE, 8'h00, 8'h00, FLAG_BYTE, 16'h0},
                6'b000100);
        add_row(KIND_PAYLOAD, 8'hFF, 1'b1, 4, {FLAG_BYTE, 8'hFF, 8'hFF, FLAG_BYTE, 16'h0},
                6'b000100);
        // Single-byte frames whose byte and check byte both need escaping,
        // which gives the longest expansion of one word.
        add_row(KIND_PAYLOAD, FLAG_BYTE, 1'b1, 6,
                {FLAG_BYTE, ESC_BYTE, FLAG_BYTE ^ ESC_MASK, ESC_BYTE, FLAG_BYTE ^ ESC_MASK,
                 FLAG_BYTE}, 6'b000001);
        add_row(KIND_PAYLOAD, ESC_BYTE, 1'b1, 6,
                {FLAG_BYTE, ESC_BYTE, ESC_BYTE ^ ESC_MASK, ESC_BYTE, ESC_BYTE ^ ESC_MASK,
                 FLAG_BYTE}, 6'b000001);
        // A frame that opens on a flag byte and goes on with an escape byte.
        add_row(KIND_PAYLOAD, FLAG_BYTE, 1'b0, 3,
                {FLAG_BYTE, ESC_BYTE, FLAG_BYTE ^ ESC_MASK, 24'h0}, 6'b000000);
        add_row(KIND_PAYLOAD, ESC_BYTE, 1'b0, 2,
                {ESC_BYTE, ESC_BYTE ^ ESC_MASK, 32'h0}, 6'b000000);
        // The escaped forms themselves pass unchanged.
        add_row(KIND_PAYLOAD, 8'h5E, 1'b0, 0, '0, '0);
        add_row(KIND_PAYLOAD, 8'h5D, 1'b1, 0, '0, '0);
        // An empty frame arriving while a frame is open closes it first.
        add_row(KIND_PAYLOAD, 8'h12, 1'b0, 0, '0, '0);
        add_row(KIND_EMPTY, 8'h34, 1'b0, 0, '0, '0);
        // Check bytes that come out as the escape byte and as the flag.
        add_row(KIND_PAYLOAD, FLAG_BYTE, 1'b0, 0, '0, '0);
        add_row(KIND_PAYLOAD, 8'h03, 1'b1, 0, '0, '0);
        add_row(KIND_PAYLOAD, 8'h20, 1'b0, 0, '0, '0);
        add_row(KIND_PAYLOAD, 8'h5E, 1'b1, 0, '0, '0);
        // Complementary bytes give an all-ones check byte.
        add_row(KIND_PAYLOAD, 8'hAA, 1'b0, 0, '0, '0);
        add_row(KIND_PAYLOAD, 8'h55, 1'b1, 0, '0, '0);
        add_row(KIND_PAYLOAD, 8'h80, 1'b0, 0, '0, '0);
        add_row(KIND_EMPTY, FLAG_BYTE, 1'b1, 0, '0, '0);
        // Equal bytes cancel to a zero check byte.
        add_row(KIND_PAYLOAD, 8'h01, 1'b0, 0, '0, '0);
        add_row(KIND_PAYLOAD, 8'h01, 1'b1, 0, '0, '0);
        add_row(KIND_EMPTY, 8'h00, 1'b0, 0, '0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[r]) begin
            row = dir_tab[r];
            if (row.n_fixed == 0) begin
                send_checked(row.kind, row.data, row.last);
            end else begin
                offer_word(row.kind, row.data, row.last);
                // The expander still runs so that its state follows along.
                expand_word(row.kind, row.data, row.last);
                for (i = 0; i < row.n_fixed; i++) begin
                    w.line = row.fixed_line[i];
                    w.done = row.fixed_done[i];
                    w.last = (i == row.n_fixed - 1);
                    line_q.push_back(w);
                end
            end
        end

        // Random frames with idling on both sides.
        while (words_sent < 170) begin
            send_random_frame();
        end

        // The sender waits until the block has sent every owed line word.
        drain_lines();

        // The receiver holds off for a long stretch while the sender keeps
        // offering words, so the block backs up and stalls its input.
        hold_req = 1'b1;
        while (words_sent < 215) begin
            send_random_frame();
        end

        while (words_sent < 350) begin
            send_random_frame();
        end

        // The last part of the run goes at full rate on both sides.
        idle_on = 1'b0;
        while (words_sent < 430) begin
            send_random_frame();
        end

        drain_lines();
        // The extra wait catches any line word the block should not send.
        repeat (20) @(posedge clk);

        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
